// ----- design/stt_pkg.sv -----
// Shared types, token kinds, character codes and keyword helpers for the
// source text tokenizer. No dependencies; every design file imports it.
package stt_pkg;

    // Most results one input item can cause
    localparam int MaxRes = 3;

    // Scanner modes
    typedef enum logic [2:0] {
        MODE_IDLE = 3'd0,
        MODE_NUM  = 3'd1,
        MODE_WORD = 3'd2,
        MODE_STR  = 3'd3,
        MODE_EQ   = 3'd4
    } lex_mode_t;

    // Token kinds
    localparam logic [3:0] K_NUM    = 4'd0;
    localparam logic [3:0] K_EQ     = 4'd1;
    localparam logic [3:0] K_PLUS   = 4'd2;
    localparam logic [3:0] K_VAR    = 4'd3;
    localparam logic [3:0] K_IDENT  = 4'd4;
    localparam logic [3:0] K_LPAREN = 4'd5;
    localparam logic [3:0] K_RPAREN = 4'd6;
    localparam logic [3:0] K_STRING = 4'd7;
    localparam logic [3:0] K_SEMI   = 4'd8;
    localparam logic [3:0] K_IF     = 4'd9;
    localparam logic [3:0] K_ELIF   = 4'd10;
    localparam logic [3:0] K_ELSE   = 4'd11;
    localparam logic [3:0] K_LBRACE = 4'd12;
    localparam logic [3:0] K_RBRACE = 4'd13;
    localparam logic [3:0] K_EQEQ   = 4'd14;

    // Character codes
    localparam logic [7:0] CH_EQ     = 8'h3D;
    localparam logic [7:0] CH_PLUS   = 8'h2B;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_SEMI   = 8'h3B;
    localparam logic [7:0] CH_LBRACE = 8'h7B;
    localparam logic [7:0] CH_RBRACE = 8'h7D;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_NL     = 8'h0A;

    // Keyword slots in the match mask
    localparam logic [1:0] KW_VAR  = 2'd0;
    localparam logic [1:0] KW_IF   = 2'd1;
    localparam logic [1:0] KW_ELIF = 2'd2;
    localparam logic [1:0] KW_ELSE = 2'd3;

    // One result item
    typedef struct packed {
        logic [3:0] token_kind;
        logic [7:0] value_byte;
        logic       is_content;
        logic       token_end;
        logic       unterminated;
        logic       last_of_run;
    } lex_res_t;

    function automatic logic is_digit(input logic [7:0] c);
        return (c >= 8'h30) && (c <= 8'h39);
    endfunction

    function automatic logic is_letter(input logic [7:0] c);
        return ((c >= 8'h41) && (c <= 8'h5A)) || ((c >= 8'h61) && (c <= 8'h7A));
    endfunction

    // Keyword length per slot
    function automatic logic [2:0] kw_len(input logic [1:0] k);
        logic [2:0] len;
        unique case (k)
            KW_VAR:  len = 3'd3;
            KW_IF:   len = 3'd2;
            KW_ELIF: len = 3'd4;
            KW_ELSE: len = 3'd4;
            default: len = 3'd0;
        endcase
        return len;
    endfunction

    // Keyword character at a position; zero past the end
    function automatic logic [7:0] kw_char(input logic [1:0] k, input logic [2:0] p);
        logic [7:0] ch;
        ch = 8'h00;
        unique case (k)
            KW_VAR:
                unique case (p)
                    3'd0: ch = 8'h76;
                    3'd1: ch = 8'h61;
                    3'd2: ch = 8'h72;
                    default: ch = 8'h00;
                endcase
            KW_IF:
                unique case (p)
                    3'd0: ch = 8'h69;
                    3'd1: ch = 8'h66;
                    default: ch = 8'h00;
                endcase
            KW_ELIF:
                unique case (p)
                    3'd0: ch = 8'h65;
                    3'd1: ch = 8'h6C;
                    3'd2: ch = 8'h69;
                    3'd3: ch = 8'h66;
                    default: ch = 8'h00;
                endcase
            KW_ELSE:
                unique case (p)
                    3'd0: ch = 8'h65;
                    3'd1: ch = 8'h6C;
                    3'd2: ch = 8'h73;
                    3'd3: ch = 8'h65;
                    default: ch = 8'h00;
                endcase
            default: ch = 8'h00;
        endcase
        return ch;
    endfunction

    // Drop keywords that no longer match after character c at position p
    function automatic logic [3:0] kw_update(input logic [3:0] m, input logic [2:0] p,
                                             input logic [7:0] c);
        logic [3:0] r;
        r = m;
        for (int k = 0; k < 4; k++) begin
            if ((p >= kw_len(k[1:0])) || (kw_char(k[1:0], p) != c)) begin
                r[k] = 1'b0;
            end
        end
        return r;
    endfunction

    // Final kind of a word
    function automatic logic [3:0] word_kind(input logic [3:0] m, input logic [2:0] len);
        logic [3:0] kind;
        kind = K_IDENT;
        priority if (m[KW_VAR] && (len == kw_len(KW_VAR)))
            kind = K_VAR;
        else if (m[KW_IF] && (len == kw_len(KW_IF)))
            kind = K_IF;
        else if (m[KW_ELIF] && (len == kw_len(KW_ELIF)))
            kind = K_ELIF;
        else if (m[KW_ELSE] && (len == kw_len(KW_ELSE)))
            kind = K_ELSE;
        else
            kind = K_IDENT;
        return kind;
    endfunction

endpackage

// ----- design/stt_lex_core.sv -----
// Scanner state and the combinational step that turns one character into
// up to three result items. Depends on stt_pkg.
module stt_lex_core
    import stt_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic [7:0]                char_byte,
    input  logic                      end_of_text,
    input  logic                      advance,
    output lex_res_t [MaxRes-1:0]     res,
    output logic [1:0]                res_count
);

    lex_mode_t  mode_reg, mode_next;
    logic       esc_reg, esc_next;
    logic [2:0] wlen_reg, wlen_next;
    logic [3:0] kmatch_reg, kmatch_next;

    lex_res_t [MaxRes-1:0] r;
    logic [1:0] n;
    logic       do_idle;

    // Step the scanner for the held character
    always_comb
    begin
        mode_next   = mode_reg;
        esc_next    = esc_reg;
        wlen_next   = wlen_reg;
        kmatch_next = kmatch_reg;
        r           = '0;
        n           = 2'd0;
        do_idle     = 1'b0;

        unique case (mode_reg)
            MODE_NUM:
            begin
                if (is_digit(char_byte))
                begin
                    r[n] = '{K_NUM, char_byte, 1'b1, 1'b0, 1'b0, 1'b0};
                    n = n + 2'd1;
                end
                else
                begin
                    r[n] = '{K_NUM, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0};
                    n = n + 2'd1;
                    do_idle = 1'b1;
                end
            end
            MODE_WORD:
            begin
                if (is_letter(char_byte))
                begin
                    kmatch_next = kw_update(kmatch_reg, wlen_reg, char_byte);
                    if (wlen_reg != 3'd7)
                        wlen_next = wlen_reg + 3'd1;
                    r[n] = '{K_IDENT, char_byte, 1'b1, 1'b0, 1'b0, 1'b0};
                    n = n + 2'd1;
                end
                else
                begin
                    r[n] = '{word_kind(kmatch_reg, wlen_reg), 8'h00, 1'b0, 1'b1, 1'b0, 1'b0};
                    n = n + 2'd1;
                    do_idle = 1'b1;
                end
            end
            MODE_STR:
            begin
                // Emit a held backslash unless it forms a newline escape
                if (esc_reg)
                begin
                    esc_next = 1'b0;
                    if (char_byte != CH_LOW_N)
                    begin
                        r[n] = '{K_STRING, CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0};
                        n = n + 2'd1;
                    end
                end
                if (esc_reg && (char_byte == CH_LOW_N))
                begin
                    r[n] = '{K_STRING, CH_NL, 1'b1, 1'b0, 1'b0, 1'b0};
                    n = n + 2'd1;
                end
                else if (char_byte == CH_QUOTE)
                begin
                    r[n] = '{K_STRING, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0};
                    n = n + 2'd1;
                    mode_next = MODE_IDLE;
                end
                else if (char_byte == CH_BSLASH)
                begin
                    esc_next = 1'b1;
                end
                else
                begin
                    r[n] = '{K_STRING, char_byte, 1'b1, 1'b0, 1'b0, 1'b0};
                    n = n + 2'd1;
                end
            end
            MODE_EQ:
            begin
                if (char_byte == CH_EQ)
                begin
                    r[n] = '{K_EQEQ, CH_EQ, 1'b0, 1'b1, 1'b0, 1'b0};
                    n = n + 2'd1;
                    mode_next = MODE_IDLE;
                end
                else
                begin
                    r[n] = '{K_EQ, CH_EQ, 1'b0, 1'b1, 1'b0, 1'b0};
                    n = n + 2'd1;
                    do_idle = 1'b1;
                end
            end
            default:
            begin
                do_idle = 1'b1;
            end
        endcase

        // Classify the character outside any token
        if (do_idle)
        begin
            mode_next = MODE_IDLE;
            priority if (char_byte == CH_EQ)
                mode_next = MODE_EQ;
            else if (char_byte == CH_PLUS)
            begin
                r[n] = '{K_PLUS, char_byte, 1'b0, 1'b1, 1'b0, 1'b0};
                n = n + 2'd1;
            end
            else if (char_byte == CH_LPAREN)
            begin
                r[n] = '{K_LPAREN, char_byte, 1'b0, 1'b1, 1'b0, 1'b0};
                n = n + 2'd1;
            end
            else if (char_byte == CH_RPAREN)
            begin
                r[n] = '{K_RPAREN, char_byte, 1'b0, 1'b1, 1'b0, 1'b0};
                n = n + 2'd1;
            end
            else if (char_byte == CH_SEMI)
            begin
                r[n] = '{K_SEMI, char_byte, 1'b0, 1'b1, 1'b0, 1'b0};
                n = n + 2'd1;
            end
            else if (char_byte == CH_LBRACE)
            begin
                r[n] = '{K_LBRACE, char_byte, 1'b0, 1'b1, 1'b0, 1'b0};
                n = n + 2'd1;
            end
            else if (char_byte == CH_RBRACE)
            begin
                r[n] = '{K_RBRACE, char_byte, 1'b0, 1'b1, 1'b0, 1'b0};
                n = n + 2'd1;
            end
            else if (char_byte == CH_QUOTE)
            begin
                mode_next = MODE_STR;
                esc_next  = 1'b0;
            end
            else if (is_digit(char_byte))
            begin
                mode_next = MODE_NUM;
                r[n] = '{K_NUM, char_byte, 1'b1, 1'b0, 1'b0, 1'b0};
                n = n + 2'd1;
            end
            else if (is_letter(char_byte))
            begin
                mode_next   = MODE_WORD;
                wlen_next   = 3'd1;
                kmatch_next = kw_update(4'hF, 3'd0, char_byte);
                r[n] = '{K_IDENT, char_byte, 1'b1, 1'b0, 1'b0, 1'b0};
                n = n + 2'd1;
            end
            else
            begin
                mode_next = MODE_IDLE;
            end
        end

        // Close open tokens at end of text and return to reset state
        if (end_of_text)
        begin
            unique case (mode_next)
                MODE_NUM:
                begin
                    r[n] = '{K_NUM, 8'h00, 1'b0, 1'b1, 1'b0, 1'b0};
                    n = n + 2'd1;
                end
                MODE_WORD:
                begin
                    r[n] = '{word_kind(kmatch_next, wlen_next), 8'h00, 1'b0, 1'b1, 1'b0,
                             1'b0};
                    n = n + 2'd1;
                end
                MODE_STR:
                begin
                    if (esc_next)
                    begin
                        r[n] = '{K_STRING, CH_BSLASH, 1'b1, 1'b0, 1'b0, 1'b0};
                        n = n + 2'd1;
                    end
                    r[n] = '{K_STRING, 8'h00, 1'b0, 1'b1, 1'b1, 1'b0};
                    n = n + 2'd1;
                end
                MODE_EQ:
                begin
                    r[n] = '{K_EQ, CH_EQ, 1'b0, 1'b1, 1'b0, 1'b0};
                    n = n + 2'd1;
                end
                default:
                begin
                    n = n;
                end
            endcase
            mode_next   = MODE_IDLE;
            esc_next    = 1'b0;
            wlen_next   = 3'd0;
            kmatch_next = 4'hF;
        end

        // Mark the final result of this item
        if (n != 2'd0)
            r[n - 2'd1].last_of_run = 1'b1;
    end

    assign res       = r;
    assign res_count = n;

    // Advance the scanner state when the item is consumed
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= MODE_IDLE;
            esc_reg    <= 1'b0;
            wlen_reg   <= 3'd0;
            kmatch_reg <= 4'hF;
        end
        else if (advance)
        begin
            mode_reg   <= mode_next;
            esc_reg    <= esc_next;
            wlen_reg   <= wlen_next;
            kmatch_reg <= kmatch_next;
        end
    end

endmodule

// ----- design/stt_out_queue.sv -----
// Result buffer: holds the up to three results of one item and hands them
// out one per cycle while out_ready is high. Depends on stt_pkg.
module stt_out_queue
    import stt_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  load,
    input  lex_res_t [MaxRes-1:0] res,
    input  logic [1:0]            res_count,
    output logic                  can_load,
    output logic                  out_valid,
    input  logic                  out_ready,
    output lex_res_t              out_res
);

    lex_res_t [MaxRes-1:0] buf_reg;
    logic [1:0] cnt_reg;
    logic [1:0] rd_reg;
    logic       pop;

    assign out_valid = (cnt_reg != 2'd0);
    assign pop       = out_valid && out_ready;
    // Room for a new set once the last held result leaves this cycle
    assign can_load  = (cnt_reg == 2'd0) || ((cnt_reg == 2'd1) && out_ready);
    assign out_res   = buf_reg[rd_reg];

    // Track fill count and read position
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cnt_reg <= 2'd0;
            rd_reg  <= 2'd0;
        end
        else if (load)
        begin
            cnt_reg <= res_count;
            rd_reg  <= 2'd0;
        end
        else if (pop)
        begin
            cnt_reg <= cnt_reg - 2'd1;
            rd_reg  <= rd_reg + 2'd1;
        end
    end

    // Capture the result set
    always_ff @(posedge clk)
    begin
        if (load)
            buf_reg <= res;
    end

endmodule

// ----- design/source_text_tokenizer_top.sv -----
// Source text tokenizer: one ASCII character per input item, an input
// register feeding the scanner step, and a result buffer. The character is
// registered, then scanned combinationally into up to three result items
// (content bytes, token closes, single-character tokens, == and string
// repairs at end of text). A character is taken every cycle as long as each
// one yields at most one result and m_tready is high; one yielding two
// or three results holds the input while the result buffer, which emits
// one item per cycle unless stalled, drains. tlast on the input marks end of
// text; tlast on the output marks the last result caused by a character.
// Depends on stt_pkg, stt_lex_core and stt_out_queue.
module source_text_tokenizer_top
    import stt_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // [7:0] char_byte
    input  logic       s_tlast,   // end_of_text
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // [7:0] value_byte
    output logic [6:0] m_tuser,   // [3:0] token_kind, [4] is_content, [5] token_end,
                                  // [6] unterminated
    output logic       m_tlast    // last_of_run
);

    logic       in_valid_reg;
    logic [7:0] in_char_reg;
    logic       in_eot_reg;

    lex_res_t [MaxRes-1:0] res;
    logic [1:0] res_count;
    logic       can_load;
    logic       advance;
    lex_res_t   out_res;

    // Consume the held character when its results fit the buffer
    assign advance  = in_valid_reg && ((res_count == 2'd0) || can_load);
    assign s_tready = !in_valid_reg || advance;

    // Hold the incoming character
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            in_valid_reg <= 1'b0;
        else if (s_tready)
            in_valid_reg <= s_tvalid;
    end

    always_ff @(posedge clk)
    begin
        if (s_tready && s_tvalid)
        begin
            in_char_reg <= s_tdata;
            in_eot_reg  <= s_tlast;
        end
    end

    stt_lex_core u_core (
        .clk         (clk),
        .rst_n       (rst_n),
        .char_byte   (in_char_reg),
        .end_of_text (in_eot_reg),
        .advance     (advance),
        .res         (res),
        .res_count   (res_count)
    );

    stt_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (advance && (res_count != 2'd0)),
        .res       (res),
        .res_count (res_count),
        .can_load  (can_load),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (out_res)
    );

    assign m_tdata = out_res.value_byte;
    assign m_tuser = {out_res.unterminated, out_res.token_end, out_res.is_content,
                      out_res.token_kind};
    assign m_tlast = out_res.last_of_run;

endmodule

// ----- sim/source_text_tokenizer_top_tb.sv -----
`timescale 1ns / 1ps
// Self-checking testbench for source_text_tokenizer_top: a directed character
// table, then random source text, every result item checked against the table or a scanner model.
// Depends on stt_pkg and the tokenizer RTL.
module source_text_tokenizer_top_tb;
    import stt_pkg::*;

    localparam int RandItems = 200;
    localparam int LimitNs   = 500000;

    // How a directed row is checked
    typedef enum logic [1:0] {
        ROW_PREDICT = 2'd0,
        ROW_SILENT  = 2'd1,
        ROW_ONE     = 2'd2
    } row_chk_t;

    typedef struct packed {
        logic [7:0] ch;
        logic       eot;
        row_chk_t   chk;
        logic [3:0] kind;
        logic [7:0] val;
    } dir_row_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;
    logic       s_tlast  = 1'b0;
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;
    logic [6:0] m_tuser;
    logic       m_tlast;

    // Scanner model state
    lex_mode_t  scan_mode;
    logic       scan_esc;
    logic [2:0] scan_len;
    logic [3:0] scan_match;
    lex_res_t   step_buf[MaxRes];
    int         step_n;

    // Predicted result items, oldest first
    lex_res_t   token_q[$];
    logic [7:0] text_frag[$];

    bit         sender_calm = 1'b0;
    int         errors = 0;
    int         results_seen = 0;
    int         chars_sent = 0;
    int         eot_marks = 0;
    int         unterm_closes = 0;
    int         kinds_hit[16];

    source_text_tokenizer_top u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
        errors++;
        $display("[%0t] MISMATCH: %s", $time, msg);
    endtask

    task automatic check_field(input string name, input int got, input int want);
        if (got != want)
        begin
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
        end
    endtask

    // Append a character to the fragment being built
    task automatic frag_add(input logic [7:0] c);
        text_frag.insert(text_frag.size(), c);
    endtask

    // Append a predicted result item
    task automatic expect_add(input lex_res_t r);
        token_q.insert(token_q.size(), r);
    endtask

    function automatic string keyword_text(input logic [1:0] k);
        case (k)
            KW_VAR:  return "var";
            KW_IF:   return "if";
            KW_ELIF: return "elif";
            default: return "else";
        endcase
    endfunction

    function automatic logic [3:0] keyword_kind(input logic [1:0] k);
        case (k)
            KW_VAR:  return K_VAR;
            KW_IF:   return K_IF;
            KW_ELIF: return K_ELIF;
            default: return K_ELSE;
        endcase
    endfunction

    function automatic bit char_is_digit(input logic [7:0] c);
        return (c >= "0") && (c <= "9");
    endfunction

    function automatic bit char_is_letter(input logic [7:0] c);
        return ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1) == 0)
            return 8'(8'h41 + $urandom_range(0, 25));
        return 8'(8'h61 + $urandom_range(0, 25));
    endfunction

    task automatic scan_reset();
        scan_mode  = MODE_IDLE;
        scan_esc   = 1'b0;
        scan_len   = 3'd0;
        scan_match = 4'hF;
    endtask

    // Append one result of the current character
    task automatic emit(input logic [3:0] kind, input logic [7:0] val, input logic content,
                        input logic fin, input logic unterm);
        lex_res_t r;
        r.token_kind   = kind;
        r.value_byte   = val;
        r.is_content   = content;
        r.token_end    = fin;
        r.unterminated = unterm;
        r.last_of_run  = 1'b0;
        if (step_n < MaxRes)
        begin
            step_buf[step_n] = r;
            step_n++;
        end
    endtask

    // Drop keywords that the new letter rules out, then count it
    task automatic word_add(input logic [7:0] c);
        string kw;
        for (int k = 0; k < 4; k++)
        begin
            kw = keyword_text(k[1:0]);
            if (scan_len >= kw.len())
                scan_match[k] = 1'b0;
            else if (kw[scan_len] != c)
                scan_match[k] = 1'b0;
        end
        if (scan_len < 3'd7)
            scan_len = scan_len + 3'd1;
    endtask

    function automatic logic [3:0] word_final();
        string kw;
        logic [3:0] kind;
        kind = K_IDENT;
        for (int k = 0; k < 4; k++)
        begin
            kw = keyword_text(k[1:0]);
            if ((kind == K_IDENT) && scan_match[k] && (scan_len == kw.len()))
                kind = keyword_kind(k[1:0]);
        end
        return kind;
    endfunction

    // Character seen outside any token
    task automatic open_token(input logic [7:0] c);
        scan_mode = MODE_IDLE;
        case (c)
            CH_EQ:     scan_mode = MODE_EQ;
            CH_PLUS:   emit(K_PLUS, c, 1'b0, 1'b1, 1'b0);
            CH_LPAREN: emit(K_LPAREN, c, 1'b0, 1'b1, 1'b0);
            CH_RPAREN: emit(K_RPAREN, c, 1'b0, 1'b1, 1'b0);
            CH_SEMI:   emit(K_SEMI, c, 1'b0, 1'b1, 1'b0);
            CH_LBRACE: emit(K_LBRACE, c, 1'b0, 1'b1, 1'b0);
            CH_RBRACE: emit(K_RBRACE, c, 1'b0, 1'b1, 1'b0);
            CH_QUOTE:
            begin
                scan_mode = MODE_STR;
                scan_esc  = 1'b0;
            end
            default:
            begin
                if (char_is_digit(c))
                begin
                    scan_mode = MODE_NUM;
                    emit(K_NUM, c, 1'b1, 1'b0, 1'b0);
                end
                else if (char_is_letter(c))
                begin
                    scan_mode  = MODE_WORD;
                    scan_len   = 3'd0;
                    scan_match = 4'hF;
                    word_add(c);
                    emit(K_IDENT, c, 1'b1, 1'b0, 1'b0);
                end
            end
        endcase
    endtask

    task automatic string_byte(input logic [7:0] c);
        if (c == CH_QUOTE)
        begin
            emit(K_STRING, 8'h00, 1'b0, 1'b1, 1'b0);
            scan_mode = MODE_IDLE;
        end
        else if (c == CH_BSLASH)
            scan_esc = 1'b1;
        else
            emit(K_STRING, c, 1'b1, 1'b0, 1'b0);
    endtask

    // Advance the model by one character; results land in step_buf
    task automatic scan_char(input logic [7:0] c, input logic eot);
        step_n = 0;
        case (scan_mode)
            MODE_NUM:
                if (char_is_digit(c))
                    emit(K_NUM, c, 1'b1, 1'b0, 1'b0);
                else
                begin
                    emit(K_NUM, 8'h00, 1'b0, 1'b1, 1'b0);
                    open_token(c);
                end
            MODE_WORD:
                if (char_is_letter(c))
                begin
                    word_add(c);
                    emit(K_IDENT, c, 1'b1, 1'b0, 1'b0);
                end
                else
                begin
                    emit(word_final(), 8'h00, 1'b0, 1'b1, 1'b0);
                    open_token(c);
                end
            MODE_STR:
                if (scan_esc)
                begin
                    scan_esc = 1'b0;
                    if (c == CH_LOW_N)
                        emit(K_STRING, CH_NL, 1'b1, 1'b0, 1'b0);
                    else
                    begin
                        emit(K_STRING, CH_BSLASH, 1'b1, 1'b0, 1'b0);
                        string_byte(c);
                    end
                end
                else
                    string_byte(c);
            MODE_EQ:
                if (c == CH_EQ)
                begin
                    emit(K_EQEQ, CH_EQ, 1'b0, 1'b1, 1'b0);
                    scan_mode = MODE_IDLE;
                end
                else
                begin
                    emit(K_EQ, CH_EQ, 1'b0, 1'b1, 1'b0);
                    open_token(c);
                end
            default:
                open_token(c);
        endcase

        // Close whatever is open at end of text
        if (eot)
        begin
            case (scan_mode)
                MODE_NUM:  emit(K_NUM, 8'h00, 1'b0, 1'b1, 1'b0);
                MODE_WORD: emit(word_final(), 8'h00, 1'b0, 1'b1, 1'b0);
                MODE_STR:
                begin
                    if (scan_esc)
                        emit(K_STRING, CH_BSLASH, 1'b1, 1'b0, 1'b0);
                    emit(K_STRING, 8'h00, 1'b0, 1'b1, 1'b1);
                end
                MODE_EQ:   emit(K_EQ, CH_EQ, 1'b0, 1'b1, 1'b0);
                default:   ;
            endcase
            scan_reset();
        end
    endtask

    function automatic int pick_gap();
        int r;
        if (sender_calm)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 65)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(6, 24);
    endfunction

    // Offer one character, wait for the handshake, then record its results
    task automatic push_char(input logic [7:0] c, input logic eot, input row_chk_t chk,
                             input logic [3:0] kind, input logic [7:0] val);
        int gap;
        lex_res_t r;
        gap = pick_gap();
        if (gap > 0)
        begin
            s_tvalid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eot;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        scan_char(c, eot);
        chars_sent++;
        if (eot)
            eot_marks++;
        if (chk == ROW_PREDICT)
        begin
            for (int i = 0; i < step_n; i++)
            begin
                r = step_buf[i];
                r.last_of_run = (i == step_n - 1);
                expect_add(r);
            end
        end
        else if (chk == ROW_ONE)
        begin
            r.token_kind   = kind;
            r.value_byte   = val;
            r.is_content   = 1'b0;
            r.token_end    = 1'b1;
            r.unterminated = 1'b0;
            r.last_of_run  = 1'b1;
            expect_add(r);
        end
        @(negedge clk);
    endtask

    // Hold the sender until every predicted result has come out
    task automatic wait_results_drained();
        s_tvalid <= 1'b0;
        do
            @(negedge clk);
        while (token_q.size() != 0);
    endtask

    function automatic dir_row_t mk_row(input logic [7:0] ch, input logic eot,
                                        input row_chk_t chk, input logic [3:0] kind,
                                        input logic [7:0] val);
        dir_row_t row;
        row.ch   = ch;
        row.eot  = eot;
        row.chk  = chk;
        row.kind = kind;
        row.val  = val;
        return row;
    endfunction

    // Build one random piece of source text; noise and spaces are not counted
    task automatic build_fragment(output bit counted);
        int pick;
        int n;
        int variant;
        string kw;
        logic [7:0] c;
        text_frag.delete();
        counted = 1'b1;
        pick = $urandom_range(0, 99);
        if (pick < 20)
        begin
            kw = keyword_text(2'($urandom_range(0, 3)));
            for (int i = 0; i < kw.len(); i++)
                frag_add(kw[i]);
        end
        else if (pick < 30)
        begin
            // near-keywords: cut short, extended, or capitalized
            kw = keyword_text(2'($urandom_range(0, 3)));
            variant = $urandom_range(0, 2);
            for (int i = 0; i < kw.len(); i++)
            begin
                c = kw[i];
                if ((variant == 2) && (i == 0))
                    c = c - 8'h20;
                if (!((variant == 0) && (i == kw.len() - 1)))
                    frag_add(c);
            end
            if (variant == 1)
                frag_add(rand_letter());
        end
        else if (pick < 40)
        begin
            n = $urandom_range(1, 9);
            repeat (n) frag_add(rand_letter());
        end
        else if (pick < 52)
        begin
            n = $urandom_range(1, 4);
            repeat (n) frag_add(8'(8'h30 + $urandom_range(0, 9)));
        end
        else if (pick < 67)
        begin
            frag_add(CH_QUOTE);
            n = $urandom_range(0, 5);
            repeat (n)
            begin
                case ($urandom_range(0, 5))
                    0:
                    begin
                        frag_add(CH_BSLASH);
                        frag_add(CH_LOW_N);
                    end
                    1:
                    begin
                        frag_add(CH_BSLASH);
                        frag_add(8'($urandom_range(0, 255)));
                    end
                    default:
                    begin
                        c = 8'($urandom_range(32, 126));
                        while ((c == CH_QUOTE) || (c == CH_BSLASH))
                            c = 8'($urandom_range(32, 126));
                        frag_add(c);
                    end
                endcase
            end
            // leave some strings open on purpose
            if ($urandom_range(0, 5) != 0)
                frag_add(CH_QUOTE);
        end
        else if (pick < 82)
        begin
            case ($urandom_range(0, 6))
                0:       frag_add(CH_EQ);
                1:       frag_add(CH_PLUS);
                2:       frag_add(CH_LPAREN);
                3:       frag_add(CH_RPAREN);
                4:       frag_add(CH_SEMI);
                5:       frag_add(CH_LBRACE);
                default: frag_add(CH_RBRACE);
            endcase
        end
        else if (pick < 88)
        begin
            frag_add(CH_EQ);
            frag_add(CH_EQ);
        end
        else if (pick < 94)
        begin
            frag_add(8'h20);
            counted = 1'b0;
        end
        else
        begin
            frag_add(8'($urandom_range(0, 255)));
            counted = 1'b0;
        end
        if ((pick < 52) && ($urandom_range(0, 1) == 0))
            frag_add(8'h20);
    endtask

    // Ready side: random stalls, with calm stretches
    initial
    begin : receiver
        int stall_left;
        int cyc;
        bit calm;
        stall_left = 0;
        cyc = 0;
        calm = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            cyc++;
            if ((cyc % 97) == 0)
                calm = ($urandom_range(0, 3) == 0);
            if (stall_left > 0)
            begin
                m_tready <= 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready <= 1'b1;
                if (!calm && ($urandom_range(0, 99) < 20))
                    stall_left = ($urandom_range(0, 9) < 8) ? $urandom_range(1, 3)
                                                            : $urandom_range(6, 24);
            end
        end
    end

    // Compare each accepted result with the oldest prediction
    always @(posedge clk)
    begin : result_check
        lex_res_t got;
        lex_res_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got.token_kind   = m_tuser[3:0];
            got.value_byte   = m_tdata;
            got.is_content   = m_tuser[4];
            got.token_end    = m_tuser[5];
            got.unterminated = m_tuser[6];
            got.last_of_run  = m_tlast;
            results_seen++;
            kinds_hit[got.token_kind]++;
            if (got.unterminated)
                unterm_closes++;
            if (token_q.size() == 0)
                report_mismatch($sformatf("result kind %0d value 0x%0h with none expected",
                                          got.token_kind, got.value_byte));
            else
            begin
                want = token_q.pop_front();
                check_field("token_kind", got.token_kind, want.token_kind);
                check_field("value_byte", got.value_byte, want.value_byte);
                check_field("is_content", got.is_content, want.is_content);
                check_field("token_end", got.token_end, want.token_end);
                check_field("unterminated", got.unterminated, want.unterminated);
                check_field("last_of_run", got.last_of_run, want.last_of_run);
            end
        end
    end

    initial
    begin : stimulus
        dir_row_t rows[$];
        bit counted;
        logic eot;
        int rand_items;
        int kinds_seen;

        scan_reset();
        for (int k = 0; k < 16; k++)
            kinds_hit[k] = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        repeat (2) @(negedge clk);

        // Directed: single-character tokens, extremes, ==, strings, end of text
        rows = {rows, mk_row(CH_PLUS, 1'b0, ROW_ONE, K_PLUS, CH_PLUS)};
        rows = {rows, mk_row(CH_LPAREN, 1'b0, ROW_ONE, K_LPAREN, CH_LPAREN)};
        rows = {rows, mk_row(CH_RPAREN, 1'b0, ROW_ONE, K_RPAREN, CH_RPAREN)};
        rows = {rows, mk_row(CH_SEMI, 1'b0, ROW_ONE, K_SEMI, CH_SEMI)};
        rows = {rows, mk_row(CH_LBRACE, 1'b0, ROW_ONE, K_LBRACE, CH_LBRACE)};
        rows = {rows, mk_row(CH_RBRACE, 1'b0, ROW_ONE, K_RBRACE, CH_RBRACE)};
        rows = {rows, mk_row(8'hFF, 1'b0, ROW_SILENT, K_NUM, 8'h00)};
        rows = {rows, mk_row(8'h00, 1'b0, ROW_SILENT, K_NUM, 8'h00)};
        rows = {rows, mk_row(CH_EQ, 1'b0, ROW_SILENT, K_NUM, 8'h00)};
        rows = {rows, mk_row(CH_EQ, 1'b0, ROW_ONE, K_EQEQ, CH_EQ)};
        rows = {rows, mk_row("i", 1'b0, ROW_PREDICT, K_NUM, 8'h00)};
        rows = {rows, mk_row("f", 1'b0, ROW_PREDICT, K_NUM, 8'h00)};
        // quote closes the keyword and opens a string
        rows = {rows, mk_row(CH_QUOTE, 1'b0, ROW_PREDICT, K_NUM, 8'h00)};
        rows = {rows, mk_row(CH_BSLASH, 1'b0, ROW_PREDICT, K_NUM, 8'h00)};
        rows = {rows, mk_row("n", 1'b0, ROW_PREDICT, K_NUM, 8'h00)};
        // stray backslash before the closing quote
        rows = {rows, mk_row(CH_BSLASH, 1'b0, ROW_PREDICT, K_NUM, 8'h00)};
        rows = {rows, mk_row(CH_QUOTE, 1'b0, ROW_PREDICT, K_NUM, 8'h00)};
        // empty string
        rows = {rows, mk_row(CH_QUOTE, 1'b0, ROW_PREDICT, K_NUM, 8'h00)};
        rows = {rows, mk_row(CH_QUOTE, 1'b0, ROW_PREDICT, K_NUM, 8'h00)};
        // number, then a lone = left pending at end of text
        rows = {rows, mk_row("9", 1'b0, ROW_PREDICT, K_NUM, 8'h00)};
        rows = {rows, mk_row(CH_EQ, 1'b1, ROW_PREDICT, K_NUM, 8'h00)};
        // unterminated string with a pending backslash
        rows = {rows, mk_row(CH_QUOTE, 1'b0, ROW_PREDICT, K_NUM, 8'h00)};
        rows = {rows, mk_row(CH_BSLASH, 1'b1, ROW_PREDICT, K_NUM, 8'h00)};
        // one-letter word closed by end of text
        rows = {rows, mk_row("z", 1'b1, ROW_PREDICT, K_NUM, 8'h00)};

        foreach (rows[i])
            push_char(rows[i].ch, rows[i].eot, rows[i].chk, rows[i].kind, rows[i].val);
        wait_results_drained();

        // Random source text
        rand_items = 0;
        while (rand_items < RandItems)
        begin
            build_fragment(counted);
            if ($urandom_range(0, 15) == 0)
                sender_calm = !sender_calm;
            foreach (text_frag[i])
            begin
                eot = ((i == text_frag.size() - 1) && ($urandom_range(0, 7) == 0))
                      || ($urandom_range(0, 59) == 0);
                push_char(text_frag[i], eot, ROW_PREDICT, K_NUM, 8'h00);
            end
            if (counted)
                rand_items += text_frag.size();
            if ($urandom_range(0, 39) == 0)
                wait_results_drained();
        end

        // Drain, then give late extra results a chance to show up
        wait_results_drained();
        repeat (20) @(posedge clk);
        if (token_q.size() != 0)
            report_mismatch($sformatf("%0d expected results never arrived", token_q.size()));

        kinds_seen = 0;
        for (int k = 0; k < 15; k++)
            if (kinds_hit[k] != 0)
                kinds_seen++;
        $display("Run covered %0d characters (%0d end-of-text marks) and %0d result items",
                 chars_sent, eot_marks, results_seen);
        $display("Token kinds seen: %0d of 15, unterminated string closes: %0d, errors: %0d",
                 kinds_seen, unterm_closes, errors);
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog
    initial
    begin : watchdog
        #(LimitNs);
        $display("Timeout at %0t with %0d results outstanding", $time, token_q.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule
